[rtl/gcpb_pkg.sv]
// shared constants and types for the glyph column page blitter
`timescale 1ns / 1ps
`default_nettype none
package gcpb_pkg;

  // display geometry
  localparam int HALF_WIDTH   = 64;
  localparam int PAGE_COUNT   = 8;
  localparam int SCREEN_WIDTH = 2 * HALF_WIDTH;
  localparam int NUM_SLOTS    = 4;

  // widths fixed by the item fields
  localparam int COL_W  = 8;
  localparam int ROW_W  = 8;
  localparam int BYTE_W = 8;
  localparam int PAGE_W = 3;
  localparam int LCOL_W = 6;
  localparam int SLOT_W = $clog2(NUM_SLOTS);

  // one page write waiting in the result bank
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [BYTE_W-1:0] pattern;
    logic              last;
  } gcpb_wr_t;

  // everything one glyph column produces
  typedef struct packed {
    logic [NUM_SLOTS-1:0]           mask;
    gcpb_wr_t [NUM_SLOTS-1:0]       wr;
    logic                           right_half;
    logic [LCOL_W-1:0]              column;
    logic [COL_W-1:0]               counter_nxt;
  } gcpb_blit_t;

endpackage
`default_nettype wire

[rtl/gcpb_decode.sv]
// splits one shifted glyph column into up to four page writes
`timescale 1ns / 1ps
`default_nettype none
module gcpb_decode (
  input  wire logic                         load_position,
  input  wire logic [gcpb_pkg::COL_W-1:0]   start_column,
  input  wire logic [gcpb_pkg::ROW_W-1:0]   pixel_row,
  input  wire logic                         tall_font,
  input  wire logic [gcpb_pkg::BYTE_W-1:0]  top_byte,
  input  wire logic [gcpb_pkg::BYTE_W-1:0]  middle_byte,
  input  wire logic [gcpb_pkg::BYTE_W-1:0]  bottom_byte,
  input  wire logic                         clear_mode,
  input  wire logic [gcpb_pkg::COL_W-1:0]   counter,
  output gcpb_pkg::gcpb_blit_t              blit
);
  import gcpb_pkg::*;

  logic [COL_W-1:0]      cnt_eff;
  logic                  on_screen;
  logic                  half;
  logic [LCOL_W-1:0]     lcol;
  logic [COL_W-1:0]      cnt_next;
  logic [2:0]            shift;
  logic [4:0]            page0;
  logic [2*BYTE_W-1:0]   w0, w1, w2;
  logic [5:0]            pg   [NUM_SLOTS];
  logic [BYTE_W-1:0]     byt  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  use_slot;
  logic [NUM_SLOTS-1:0]  hit;
  logic [COL_W:0]        cnt_inc;

  // column position
  always_comb begin
    cnt_eff   = load_position ? start_column : counter;
    on_screen = {1'b0, cnt_eff} < (COL_W+1)'(SCREEN_WIDTH);
    half      = {1'b0, cnt_eff} >= (COL_W+1)'(HALF_WIDTH);
    lcol      = half ? LCOL_W'(cnt_eff - COL_W'(HALF_WIDTH))
                     : LCOL_W'(cnt_eff);
    cnt_inc   = {1'b0, cnt_eff} + (COL_W+1)'(1);
    cnt_next  = on_screen ? cnt_inc[COL_W-1:0] : cnt_eff;
  end

  // shifted bytes, the high half of each shifted word is the carry into the next page
  always_comb begin
    shift = pixel_row[2:0];
    page0 = pixel_row[ROW_W-1:3];
    w0 = {{BYTE_W{1'b0}}, top_byte}    << shift;
    w1 = {{BYTE_W{1'b0}}, middle_byte} << shift;
    w2 = {{BYTE_W{1'b0}}, bottom_byte} << shift;
    pg[0]  = {1'b0, page0};
    byt[0] = w0[BYTE_W-1:0];
    if (tall_font) begin
      // tall font wraps past the last negative page back to page 0
      pg[1]  = {1'b0, 5'(page0 + 5'd1)};
      pg[2]  = {1'b0, 5'(page0 + 5'd2)};
      pg[3]  = {1'b0, 5'(page0 + 5'd3)};
      byt[1] = w1[BYTE_W-1:0] | w0[2*BYTE_W-1:BYTE_W];
      byt[2] = w2[BYTE_W-1:0] | w1[2*BYTE_W-1:BYTE_W];
      byt[3] = w2[2*BYTE_W-1:BYTE_W];
      use_slot = 4'b1111;
    end else begin
      pg[1]  = {1'b0, page0} + 6'd1;
      pg[2]  = '0;
      pg[3]  = '0;
      byt[1] = w0[2*BYTE_W-1:BYTE_W];
      byt[2] = '0;
      byt[3] = '0;
      use_slot = 4'b0011;
    end
  end

  // visible nonzero bytes become writes, the highest one carries last
  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hit[k] = on_screen && use_slot[k] && (pg[k] < 6'(PAGE_COUNT)) && (byt[k] != '0);
    end
    blit.mask        = hit;
    blit.right_half  = half;
    blit.column      = lcol;
    blit.counter_nxt = cnt_next;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      blit.wr[k].page    = pg[k][PAGE_W-1:0];
      blit.wr[k].pattern = clear_mode ? '0 : byt[k];
      blit.wr[k].last    = hit[k] && ((hit >> (k + 1)) == '0);
    end
  end

endmodule
`default_nettype wire

[rtl/gcpb_queue.sv]
// result bank that hands out page writes one per cycle while wr_ready is high
`timescale 1ns / 1ps
`default_nettype none
module gcpb_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire gcpb_pkg::gcpb_blit_t       blit,
  output logic                            can_load,
  output logic                            wr_valid,
  input  wire logic                       wr_ready,
  output gcpb_pkg::gcpb_wr_t              wr,
  output logic                            wr_half,
  output logic [gcpb_pkg::LCOL_W-1:0]     wr_column
);
  import gcpb_pkg::*;

  logic [NUM_SLOTS-1:0]     valid_r, valid_nxt;
  gcpb_wr_t [NUM_SLOTS-1:0] slot_r;
  logic                     half_r;
  logic [LCOL_W-1:0]        col_r;
  logic [SLOT_W-1:0]        head;
  logic                     take;
  logic                     one_left;

  // lowest pending slot goes out first
  always_comb begin
    head = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (valid_r[k]) head = SLOT_W'(k);
    end
  end

  assign wr_valid  = |valid_r;
  assign wr        = slot_r[head];
  assign wr_half   = half_r;
  assign wr_column = col_r;
  assign take      = wr_valid && wr_ready;
  assign one_left  = (valid_r & (valid_r - NUM_SLOTS'(1))) == '0;
  assign can_load  = (valid_r == '0) || (one_left && take);

  // pending mask
  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt[head] = 1'b0;
    if (load) valid_nxt = blit.mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= blit.wr;
      half_r <= blit.right_half;
      col_r  <= blit.column;
    end
  end

endmodule
`default_nettype wire

[rtl/glyph_column_page_blitter.sv]
// top level of the glyph column page blitter
//
// Each request on the input stream is one glyph column; it turns into zero to four
// page writes on the output stream (two at most for the small font), lowest page
// slot first, with tlast on the final write of the column. The column is decoded
// in the cycle it is taken and its writes are parked in a four-entry result bank;
// the bank drains one write per cycle while out_tready is high, and the next column
// is taken in the cycle the last write of the previous one leaves. A column with no
// visible write parks nothing in the bank. The column counter is updated at the
// input handshake and advances only while the column is on screen.
`timescale 1ns / 1ps
`default_nettype none
module glyph_column_page_blitter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // start_column[7:0], pixel_row[15:8], top_byte[23:16], middle_byte[31:24],
  // bottom_byte[39:32]
  input  wire logic [39:0] in_tdata,
  // load_position[0], tall_font[1], clear_mode[2]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // page[2:0], column[8:3], pattern[16:9], zero[23:17]
  output logic [23:0]      out_tdata,
  // right_half[0]
  output logic             out_tuser,
  // last_write
  output logic             out_tlast
);
  import gcpb_pkg::*;

  logic [COL_W-1:0] counter_r;
  gcpb_blit_t       blit;
  gcpb_wr_t         wr;
  logic             wr_half;
  logic [LCOL_W-1:0] wr_column;
  logic             can_load;
  logic             in_take;

  assign in_tready = can_load;
  assign in_take   = in_tvalid && in_tready;

  // column decode
  gcpb_decode u_decode (
    .load_position (in_tuser[0]),
    .start_column  (in_tdata[7:0]),
    .pixel_row     (in_tdata[15:8]),
    .tall_font     (in_tuser[1]),
    .top_byte      (in_tdata[23:16]),
    .middle_byte   (in_tdata[31:24]),
    .bottom_byte   (in_tdata[39:32]),
    .clear_mode    (in_tuser[2]),
    .counter       (counter_r),
    .blit          (blit)
  );

  // result bank
  gcpb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take),
    .blit      (blit),
    .can_load  (can_load),
    .wr_valid  (out_tvalid),
    .wr_ready  (out_tready),
    .wr        (wr),
    .wr_half   (wr_half),
    .wr_column (wr_column)
  );

  // running column counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (in_take) begin
      counter_r <= blit.counter_nxt;
    end
  end

  assign out_tdata = {7'd0, wr.pattern, wr_column, wr.page};
  assign out_tuser = wr_half;
  assign out_tlast = wr.last;

  // last write leaving with no new column empties the output
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !in_take) |=> !out_tvalid)
    else $error("writes left after final write of a column");

  // a column is never taken while a pending write is stalled on the output
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken over a stalled result");

  // an off-screen column taken without a position load produces nothing and holds the counter
  a_off_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && !in_tuser[0] && (counter_r >= 8'(SCREEN_WIDTH)))
      |=> (!out_tvalid && $stable(counter_r)))
    else $error("off-screen column wrote or moved the counter");

endmodule
`default_nettype wire

[bench/glyph_column_page_blitter_tb.sv]
// self-checking testbench for the glyph column page blitter
`timescale 1ns / 1ps
module glyph_column_page_blitter_tb;
  import gcpb_pkg::*;

  localparam int PAGE_WRAP   = 32;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 8;
  localparam int RANDOM_REQS = 440;
  localparam int SEGMENT_LEN = 40;
  localparam int SHOWN_MAX   = 10;

  // pacing levels for both stream sides
  typedef enum int {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_e;

  // one glyph column request
  typedef struct packed {
    logic       load_position;
    logic [7:0] start_column;
    logic [7:0] pixel_row;
    logic       tall_font;
    logic [7:0] top_byte;
    logic [7:0] middle_byte;
    logic [7:0] bottom_byte;
    logic       clear_mode;
  } glyph_column_t;

  // one page write on the display bus
  typedef struct packed {
    logic              right_half;
    logic [PAGE_W-1:0] page;
    logic [LCOL_W-1:0] column;
    logic [7:0]        pattern;
    logic              last_write;
  } page_write_t;

  // predicts page writes per glyph column and checks them in order
  class blit_scoreboard;
    page_write_t writes_due[$];
    logic [7:0]  column_counter;
    int          mismatches;
    int          columns_taken;
    int          writes_checked;

    function new();
      column_counter = '0;
      mismatches     = 0;
      columns_taken  = 0;
      writes_checked = 0;
    endfunction

    function int pending();
      return writes_due.size();
    endfunction

    // bits of b that spill into the next page
    function int spill(int b, int shift);
      if (shift == 0) return 0;
      return (b & 8'hFF) >> (8 - shift);
    endfunction

    function void note_column(glyph_column_t c);
      int shift;
      int pages[4];
      int bytes[4];
      int nb;
      int k;
      int first;
      logic       half;
      logic [5:0] lcol;
      page_write_t w;
      columns_taken++;
      if (c.load_position) column_counter = c.start_column;
      if (int'(column_counter) >= SCREEN_WIDTH) return;
      half  = int'(column_counter) >= HALF_WIDTH;
      lcol  = half ? 6'(int'(column_counter) - HALF_WIDTH) : 6'(column_counter);
      shift = int'(c.pixel_row) % 8;
      pages[0] = int'(c.pixel_row) / 8;
      bytes[0] = (int'(c.top_byte) << shift) & 8'hFF;
      if (c.tall_font) begin
        for (k = 1; k < 4; k++) begin
          pages[k] = (pages[k-1] + 1 == PAGE_WRAP) ? 0 : pages[k-1] + 1;
        end
        bytes[1] = ((int'(c.middle_byte) << shift) | spill(c.top_byte, shift)) & 8'hFF;
        bytes[2] = ((int'(c.bottom_byte) << shift) | spill(c.middle_byte, shift)) & 8'hFF;
        bytes[3] = spill(c.bottom_byte, shift);
        nb = 4;
      end else begin
        pages[1] = pages[0] + 1;
        bytes[1] = spill(c.top_byte, shift);
        nb = 2;
      end
      first = writes_due.size();
      for (k = 0; k < nb; k++) begin
        if (pages[k] < PAGE_COUNT && bytes[k] != 0) begin
          w.right_half = half;
          w.page       = PAGE_W'(pages[k]);
          w.column     = lcol;
          w.pattern    = c.clear_mode ? 8'h00 : 8'(bytes[k]);
          w.last_write = 1'b0;
          writes_due.push_back(w);
        end
      end
      if (writes_due.size() > first) writes_due[writes_due.size()-1].last_write = 1'b1;
      column_counter = column_counter + 8'd1;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= SHOWN_MAX) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_write(page_write_t got, logic [6:0] pad);
      page_write_t exp;
      writes_checked++;
      if (writes_due.size() == 0) begin
        flag($sformatf("unexpected write half=%0d page=%0d col=%0d pattern=%02h last=%0d",
                       got.right_half, got.page, got.column, got.pattern, got.last_write));
        return;
      end
      exp = writes_due.pop_front();
      if (got.right_half !== exp.right_half)
        flag($sformatf("right_half exp %0d got %0d", exp.right_half, got.right_half));
      if (got.page !== exp.page)
        flag($sformatf("page exp %0d got %0d", exp.page, got.page));
      if (got.column !== exp.column)
        flag($sformatf("column exp %0d got %0d", exp.column, got.column));
      if (got.pattern !== exp.pattern)
        flag($sformatf("pattern exp %02h got %02h", exp.pattern, got.pattern));
      if (got.last_write !== exp.last_write)
        flag($sformatf("last_write exp %0d got %0d", exp.last_write, got.last_write));
      if (pad !== 7'd0)
        flag($sformatf("tdata pad bits exp 00 got %02h", pad));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  blit_scoreboard sb;
  pace_e          src_pace;
  pace_e          sink_pace;
  int             idle_cycles;

  glyph_column_page_blitter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap(pace_e pace);
    int r;
    r = $urandom_range(0, 99);
    case (pace)
      PACE_STEADY: return 0;
      PACE_LIGHT: begin
        if (r < 80) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
      end
      default: begin
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
      end
    endcase
  endfunction

  function automatic glyph_column_t mk(logic ld, logic [7:0] start, logic [7:0] row,
                                       logic tall, logic [7:0] b0, logic [7:0] b1,
                                       logic [7:0] b2, logic clr);
    glyph_column_t c;
    c.load_position = ld;
    c.start_column  = start;
    c.pixel_row     = row;
    c.tall_font     = tall;
    c.top_byte      = b0;
    c.middle_byte   = b1;
    c.bottom_byte   = b2;
    c.clear_mode    = clr;
    return c;
  endfunction

  function automatic logic [7:0] rand_glyph_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic glyph_column_t rand_column();
    glyph_column_t c;
    int r;
    c.load_position = ($urandom_range(0, 3) == 0);
    c.start_column  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(128, 255))
                                                  : 8'($urandom_range(0, 127));
    r = $urandom_range(0, 7);
    // mostly visible rows, some negative ones, a share near the page wrap
    if (r < 6) c.pixel_row = 8'($urandom_range(0, 63));
    else if (r == 6) c.pixel_row = 8'($urandom_range(64, 231));
    else c.pixel_row = 8'($urandom_range(232, 255));
    c.tall_font   = 1'($urandom_range(0, 1));
    c.top_byte    = rand_glyph_byte();
    c.middle_byte = rand_glyph_byte();
    c.bottom_byte = rand_glyph_byte();
    c.clear_mode  = ($urandom_range(0, 4) == 0);
    return c;
  endfunction

  // drive one glyph column request and wait for it to be taken
  task automatic send_column(glyph_column_t c);
    int gap;
    gap = pick_gap(src_pace);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {c.bottom_byte, c.middle_byte, c.top_byte, c.pixel_row, c.start_column};
    in_tuser  <= {c.clear_mode, c.tall_font, c.load_position};
    do @(posedge clk); while (!in_tready);
    sb.note_column(c);
  endtask

  // result side back-pressure
  initial begin : sink_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap(sink_pace);
        out_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // check each accepted page write
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_write({out_tuser, out_tdata[2:0], out_tdata[8:3], out_tdata[16:9], out_tlast},
                     out_tdata[23:17]);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles, %0d writes outstanding",
               idle_cycles, sb.pending());
      $display("FAIL glyph_column_page_blitter");
      $finish;
    end
  end

  // main sequence
  initial begin
    int i;
    sb          = new();
    src_pace    = PACE_LIGHT;
    sink_pace   = PACE_LIGHT;
    idle_cycles = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: shifts, carries, fonts, skips, wraps and screen edges
    send_column(mk(0, 8'd0,   8'd0,   0, 8'hFF, 8'h00, 8'h00, 0)); // zero shift, no carry
    send_column(mk(0, 8'd0,   8'd5,   0, 8'hFF, 8'h00, 8'h00, 0)); // carry into next page
    send_column(mk(0, 8'd0,   8'd0,   1, 8'h01, 8'h80, 8'hFF, 0)); // tall, aligned
    send_column(mk(0, 8'd0,   8'd3,   1, 8'hFF, 8'hFF, 8'hFF, 0)); // tall, four writes
    send_column(mk(0, 8'd0,   8'd12,  0, 8'h00, 8'hFF, 8'hFF, 0)); // zero byte, no writes
    send_column(mk(0, 8'd0,   8'd9,   0, 8'h81, 8'h00, 8'h00, 1)); // clear mode
    send_column(mk(0, 8'd0,   8'd10,  1, 8'h00, 8'h00, 8'h00, 1)); // clear with empty glyph
    send_column(mk(0, 8'd0,   8'd7,   0, 8'h80, 8'h00, 8'h00, 0)); // only the carry survives
    send_column(mk(1, 8'd63,  8'd60,  0, 8'hF0, 8'h00, 8'h00, 0)); // last left col, page 8 cut
    send_column(mk(0, 8'd0,   8'd63,  1, 8'hFF, 8'hFF, 8'hFF, 0)); // first right col, bottom
    send_column(mk(1, 8'd127, 8'd56,  1, 8'hA5, 8'h5A, 8'hC3, 0)); // last visible column
    send_column(mk(0, 8'd0,   8'd0,   0, 8'hFF, 8'h00, 8'h00, 0)); // column 128, holds
    send_column(mk(0, 8'd0,   8'd0,   1, 8'hFF, 8'hFF, 8'hFF, 0)); // still held off screen
    send_column(mk(1, 8'd255, 8'd0,   1, 8'hFF, 8'hFF, 8'hFF, 0)); // load far off screen
    send_column(mk(1, 8'd128, 8'd8,   0, 8'hFF, 8'h00, 8'h00, 0)); // load just off screen
    send_column(mk(1, 8'd0,   8'd248, 1, 8'hFF, 8'hAA, 8'h55, 0)); // page 31 wraps to top
    send_column(mk(1, 8'd64,  8'd255, 1, 8'hFF, 8'hFF, 8'hFF, 0)); // wrap with shift 7
    send_column(mk(0, 8'd0,   8'd200, 0, 8'hFF, 8'h00, 8'h00, 0)); // small font never wraps
    send_column(mk(0, 8'd0,   8'd255, 0, 8'hFF, 8'hFF, 8'hFF, 0)); // small, page 31
    send_column(mk(1, 8'd100, 8'd40,  1, 8'h55, 8'hAA, 8'h0F, 1)); // tall clear
    send_column(mk(1, 8'd1,   8'd15,  1, 8'hFF, 8'h00, 8'h00, 0)); // sparse tall
    send_column(mk(1, 8'd127, 8'd63,  0, 8'hFF, 8'hFF, 8'hFF, 0)); // far corner

    // random part in segments of varying pace, some with no idling at all
    for (i = 0; i < RANDOM_REQS; i++) begin
      if (i % SEGMENT_LEN == 0) begin
        src_pace  = pace_e'($urandom_range(0, 2));
        sink_pace = pace_e'($urandom_range(0, 2));
      end
      send_column(rand_column());
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d glyph columns through small and tall fonts, loads, wraps and clears",
             sb.columns_taken);
    $display("checked %0d page writes, %0d mismatches", sb.writes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS glyph_column_page_blitter");
    end else begin
      $display("FAIL glyph_column_page_blitter");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gcpb_pkg.sv
rtl/gcpb_decode.sv
rtl/gcpb_queue.sv
rtl/glyph_column_page_blitter.sv
bench/glyph_column_page_blitter_tb.sv
